[design/omni_wheel_velocity_lqr_controller_defines.svh]
// Assertion helpers used by the controller sequencer (owv_lqr_ctrl)
`ifndef OMNI_WHEEL_VELOCITY_LQR_CONTROLLER_DEFINES_SVH
`define OMNI_WHEEL_VELOCITY_LQR_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OWV_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define OWV_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[design/owv_lqr_pkg.sv]
package owv_lqr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CF     = 24;
   localparam int SIG_W  = 32;
   localparam int COEF_W = 28;
   localparam int OPB_W  = 34;
   localparam int PROD_W = COEF_W + OPB_W;
   localparam int ACC_W  = 66;
   localparam int IDX_W  = 8;

   // sequencer phases
   localparam logic [2:0] PH_RATE = 3'd0;
   localparam logic [2:0] PH_KIN  = 3'd1;
   localparam logic [2:0] PH_NVM  = 3'd2;
   localparam logic [2:0] PH_FILT = 3'd3;
   localparam logic [2:0] PH_XS   = 3'd4;
   localparam logic [2:0] PH_OPT  = 3'd5;
   localparam logic [2:0] PH_LQR  = 3'd6;
   localparam logic [2:0] PH_VOLT = 3'd7;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MODE  = 8'd0;
   localparam logic [IDX_W-1:0] CSR_ALPHA = 8'd1;
   localparam logic [15:0]      ALPHA_RESET = 16'd55706;

   typedef struct packed {
      logic       load_in;
      logic       issue;
      logic       first;
      logic       wb;
      logic       load_out;
      logic [2:0] phase;
      logic [2:0] row;
      logic [2:0] term;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic out_busy;
   } status_type;

   // coefficients, 24 fraction bits
   localparam logic signed [COEF_W-1:0] ONE_C  = 28'sd16777216;
   localparam logic signed [COEF_W-1:0] RATE_K = 28'sd175691;

   localparam logic signed [COEF_W-1:0] KIN_C [3][3] = '{
      '{28'sd0, 28'sd489895, -28'sd489895},
      '{-28'sd565392, 28'sd281857, 28'sd281857},
      '{28'sd2823605, 28'sd2823605, 28'sd2823605}};

   localparam logic signed [COEF_W-1:0] A_SMITH_C [3] = '{
      28'sd13787516, 28'sd13787516, 28'sd9878425};

   localparam logic signed [COEF_W-1:0] B_MAT_C [3][3] = '{
      '{28'sd0, 28'sd671089, -28'sd671089},
      '{-28'sd773430, 28'sd387554, 28'sd387554},
      '{28'sd16555757, 28'sd16555757, 28'sd16555757}};

   localparam logic signed [COEF_W-1:0] K_LQR_C [3][6] = '{
      '{28'sd0, -28'sd123151476, 28'sd3325244, 28'sd0, -28'sd84649443, 28'sd5630434},
      '{28'sd106652762, 28'sd61575738, 28'sd3325244,
        28'sd73308045, 28'sd42323883, 28'sd5630434},
      '{-28'sd106652762, 28'sd61575738, 28'sd3325244,
        -28'sd73308045, 28'sd42323883, 28'sd5630434}};

   // multiply terms per row of a phase
   function automatic logic [2:0] phase_terms(input logic [2:0] ph);
      logic [2:0] n;
      unique case (ph)
         PH_RATE: n = 3'd1;
         PH_KIN:  n = 3'd3;
         PH_NVM:  n = 3'd4;
         PH_FILT: n = 3'd2;
         PH_XS:   n = 3'd1;
         PH_OPT:  n = 3'd5;
         PH_LQR:  n = 3'd6;
         PH_VOLT: n = 3'd1;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] phase_rows(input logic [2:0] ph);
      return (ph == PH_OPT) ? 3'd6 : 3'd3;
   endfunction

   function automatic logic [2:0] next_phase(input logic [2:0] ph, input logic mode);
      logic [2:0] n;
      unique case (ph)
         PH_RATE: n = PH_KIN;
         PH_KIN:  n = mode ? PH_OPT : PH_NVM;
         PH_NVM:  n = PH_FILT;
         PH_FILT: n = PH_XS;
         PH_XS:   n = PH_LQR;
         PH_OPT:  n = PH_LQR;
         PH_LQR:  n = PH_VOLT;
         default: n = PH_VOLT;
      endcase
      return n;
   endfunction

   // clamp to signed 32 bit
   function automatic logic signed [SIG_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(32'sh7FFFFFFF);
      lo = ACC_W'(-32'sh7FFFFFFF - 32'sd1);
      if (v > hi) return 32'sh7FFFFFFF;
      if (v < lo) return -32'sh7FFFFFFF - 32'sd1;
      return SIG_W'(v);
   endfunction

endpackage

[design/omni_wheel_velocity_lqr_controller.sv]
// The delay from input transfer to rsp_valid is the same in either predictor mode.
// One tick at a time: the next input is taken only once the result is registered.
// All terms go through the single shared multiplier, one term per cycle; after the
// last term of each matrix row the MAC pipe drains and the row is written back.
// Synchronous active-high reset clears all loop state and restores the register defaults.
module omni_wheel_velocity_lqr_controller #(
   parameter int FRAC_BITS = owv_lqr_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_wheel_speed_1,
   input  logic signed [15:0] req_wheel_speed_2,
   input  logic signed [15:0] req_wheel_speed_3,
   input  logic signed [31:0] req_ref_longitudinal,
   input  logic signed [31:0] req_ref_normal,
   input  logic signed [31:0] req_ref_angular,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_pwm_1,
   output logic [7:0]         rsp_pwm_2,
   output logic [7:0]         rsp_pwm_3,
   output logic [2:0]         rsp_direction_mask,
   output logic signed [31:0] rsp_voltage_1,
   output logic signed [31:0] rsp_voltage_2,
   output logic signed [31:0] rsp_voltage_3,
   output logic signed [31:0] rsp_body_forward,
   output logic signed [31:0] rsp_body_sideways,
   output logic signed [31:0] rsp_body_turn
);
   import owv_lqr_pkg::*;

   cmd_type    cmd;
   status_type status;

   owv_lqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   owv_lqr_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_wheel_speed_1    (req_wheel_speed_1),
      .req_wheel_speed_2    (req_wheel_speed_2),
      .req_wheel_speed_3    (req_wheel_speed_3),
      .req_ref_longitudinal (req_ref_longitudinal),
      .req_ref_normal       (req_ref_normal),
      .req_ref_angular      (req_ref_angular),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pwm_1            (rsp_pwm_1),
      .rsp_pwm_2            (rsp_pwm_2),
      .rsp_pwm_3            (rsp_pwm_3),
      .rsp_direction_mask   (rsp_direction_mask),
      .rsp_voltage_1        (rsp_voltage_1),
      .rsp_voltage_2        (rsp_voltage_2),
      .rsp_voltage_3        (rsp_voltage_3),
      .rsp_body_forward     (rsp_body_forward),
      .rsp_body_sideways    (rsp_body_sideways),
      .rsp_body_turn        (rsp_body_turn)
   );

endmodule

[design/owv_lqr_ctrl.sv]
`include "omni_wheel_velocity_lqr_controller_defines.svh"

module owv_lqr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  owv_lqr_pkg::status_type status,
   output owv_lqr_pkg::cmd_type    cmd
);
   import owv_lqr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_WB    = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] term_ff, term_in;
   logic       drain_ff, drain_in;

   // sequencer: issue the terms of a row, wait out the MAC pipe, write back, then load the result
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      row_in    = row_ff;
      term_in   = term_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.phase = phase_ff;
      cmd.row   = row_ff;
      cmd.term  = term_ff;
      cmd.first = (term_ff == 3'd0);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_ISSUE;
               phase_in    = PH_RATE;
               row_in      = 3'd0;
               term_in     = 3'd0;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            if (term_ff == phase_terms(phase_ff) - 3'd1) begin
               state_in = S_DRAIN;
               drain_in = 1'b0;
            end else begin
               term_in = term_ff + 3'd1;
            end
         end
         S_DRAIN: begin
            if (drain_ff) state_in = S_WB;
            else drain_in = 1'b1;
         end
         S_WB: begin
            cmd.wb  = 1'b1;
            term_in = 3'd0;
            if (row_ff == phase_rows(phase_ff) - 3'd1) begin
               row_in = 3'd0;
               if (phase_ff == PH_VOLT) begin
                  state_in = S_OUT;
               end else begin
                  phase_in = next_phase(phase_ff, status.mode);
                  state_in = S_ISSUE;
               end
            end else begin
               row_in   = row_ff + 3'd1;
               state_in = S_ISSUE;
            end
         end
         S_OUT: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_RATE;
         row_ff   <= 3'd0;
         term_ff  <= 3'd0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         row_ff   <= row_in;
         term_ff  <= term_in;
         drain_ff <= drain_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // checks
   `OWV_NEXT(chk_start, req_valid && !req_stall, state_ff == S_ISSUE && phase_ff == PH_RATE && row_ff == 3'd0, "transfer did not start the rate phase")
   `OWV_CHECK(chk_wb_drained, cmd.wb, $past(state_ff) == S_DRAIN, "write-back before MAC pipe drained")
   `OWV_NEXT(chk_volt_end, cmd.wb && phase_ff == PH_VOLT && row_ff == 3'd2, state_ff == S_OUT, "last voltage row did not end the tick")
   `OWV_CHECK(chk_out_free, cmd.load_out, !status.out_busy, "result overwritten while stalled")

endmodule

[design/owv_lqr_dp.sv]
module owv_lqr_dp #(
   parameter int FRAC_BITS = owv_lqr_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  owv_lqr_pkg::cmd_type    cmd,
   output owv_lqr_pkg::status_type status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   input  logic signed [15:0]      req_wheel_speed_1,
   input  logic signed [15:0]      req_wheel_speed_2,
   input  logic signed [15:0]      req_wheel_speed_3,
   input  logic signed [31:0]      req_ref_longitudinal,
   input  logic signed [31:0]      req_ref_normal,
   input  logic signed [31:0]      req_ref_angular,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_pwm_1,
   output logic [7:0]              rsp_pwm_2,
   output logic [7:0]              rsp_pwm_3,
   output logic [2:0]              rsp_direction_mask,
   output logic signed [31:0]      rsp_voltage_1,
   output logic signed [31:0]      rsp_voltage_2,
   output logic signed [31:0]      rsp_voltage_3,
   output logic signed [31:0]      rsp_body_forward,
   output logic signed [31:0]      rsp_body_sideways,
   output logic signed [31:0]      rsp_body_turn
);
   import owv_lqr_pkg::*;

   localparam int RATE_SH = CF - FRAC_BITS;
   localparam int RATE_W  = OPB_W - RATE_SH;
   localparam logic signed [ACC_W-1:0] RATE_HALF = (ACC_W'(1) << RATE_SH) >> 1;
   localparam logic signed [ACC_W-1:0] HALF16    = ACC_W'(1) << 15;
   localparam logic signed [ACC_W-1:0] HALF24    = ACC_W'(1) << 23;

   // configuration
   logic        mode_ff;
   logic [15:0] alpha_ff;

   // latched inputs
   logic signed [15:0]       spd_ff [3];
   logic signed [SIG_W-1:0]  ref_ff [3];

   // working and loop state
   logic signed [RATE_W-1:0] rate_ff [3];
   logic signed [SIG_W-1:0]  vel_ff  [3];
   logic signed [SIG_W-1:0]  nvm_ff  [3];
   logic signed [SIG_W-1:0]  old_ff  [3];
   logic signed [SIG_W-1:0]  mv_ff   [3];
   logic signed [SIG_W-1:0]  fe_ff   [3];
   logic signed [SIG_W-1:0]  sv_ff   [6];
   logic signed [SIG_W-1:0]  pbv_ff  [3];
   logic signed [SIG_W-1:0]  ci_ff   [3];
   logic signed [SIG_W-1:0]  cv_ff   [3];

   // MAC pipe
   logic signed [COEF_W-1:0] coef_in, coef_ff;
   logic signed [OPB_W-1:0]  opb_in, opb_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic                     va_ff, vb_ff, fa_ff, fb_ff;

   logic [1:0] r2, t2, tm1, tm2, tm3, orow;
   logic [2:0] svi;
   logic [16:0] alpha_c;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         alpha_ff <= ALPHA_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) mode_ff <= csr_wdata[0];
         else if (csr_index == CSR_ALPHA) alpha_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         spd_ff[0] <= req_wheel_speed_1;
         spd_ff[1] <= req_wheel_speed_2;
         spd_ff[2] <= req_wheel_speed_3;
         ref_ff[0] <= req_ref_longitudinal;
         ref_ff[1] <= req_ref_normal;
         ref_ff[2] <= req_ref_angular;
      end
   end

   // operand select for the current term
   always_comb begin
      r2      = cmd.row[1:0];
      t2      = cmd.term[1:0];
      tm1     = 2'(cmd.term - 3'd1);
      tm2     = 2'(cmd.term - 3'd2);
      tm3     = 2'(cmd.term - 3'd3);
      orow    = (cmd.row >= 3'd3) ? 2'(cmd.row - 3'd3) : cmd.row[1:0];
      svi     = mode_ff ? cmd.term : 3'(cmd.term - 3'd3);
      alpha_c = 17'h10000 - {1'b0, alpha_ff};
      coef_in = '0;
      opb_in  = '0;
      case (cmd.phase)
         PH_RATE: begin
            coef_in = RATE_K;
            opb_in  = OPB_W'(spd_ff[r2]);
         end
         PH_KIN: begin
            coef_in = KIN_C[r2][t2];
            opb_in  = OPB_W'(rate_ff[t2]);
         end
         PH_NVM: begin
            if (cmd.term == 3'd0) begin
               coef_in = A_SMITH_C[r2];
               opb_in  = OPB_W'(mv_ff[r2]);
            end else begin
               coef_in = B_MAT_C[r2][tm1];
               opb_in  = OPB_W'(cv_ff[tm1]);
            end
         end
         PH_FILT: begin
            if (cmd.term == 3'd0) begin
               coef_in = COEF_W'($signed({1'b0, alpha_c}));
               opb_in  = OPB_W'(vel_ff[r2]) - OPB_W'(mv_ff[r2]);
            end else begin
               coef_in = COEF_W'($signed({1'b0, alpha_ff}));
               opb_in  = OPB_W'(fe_ff[r2]);
            end
         end
         PH_XS: begin
            coef_in = ONE_C;
            opb_in  = OPB_W'(nvm_ff[r2]) + OPB_W'(fe_ff[r2]);
         end
         PH_OPT: begin
            if (cmd.term == 3'd0) begin
               coef_in = A_SMITH_C[(orow == 2'd2) ? 2'd2 : 2'd0];
               opb_in  = OPB_W'(vel_ff[orow]) - OPB_W'(pbv_ff[orow]);
            end else if (cmd.term == 3'd1) begin
               coef_in = (cmd.row >= 3'd3) ? ONE_C : '0;
               opb_in  = OPB_W'(vel_ff[orow]);
            end else begin
               coef_in = B_MAT_C[orow][tm2];
               opb_in  = OPB_W'(ci_ff[tm2]);
            end
         end
         PH_LQR: begin
            coef_in = K_LQR_C[r2][cmd.term];
            if (cmd.term < 3'd3) begin
               if (mode_ff) opb_in = -OPB_W'(sv_ff[t2]);
               else opb_in = OPB_W'(old_ff[t2]) - OPB_W'(sv_ff[t2]);
            end else begin
               opb_in = OPB_W'(ref_ff[tm3]) - OPB_W'(sv_ff[svi]);
            end
         end
         PH_VOLT: begin
            coef_in = ONE_C;
            opb_in  = OPB_W'(cv_ff[r2]) + OPB_W'(ci_ff[r2]);
         end
         default: ;
      endcase
   end

   // operand, product and accumulate stages
   assign prod_in = coef_ff * opb_ff;
   assign acc_in  = fb_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= cmd.issue;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      opb_ff  <= opb_in;
      fa_ff   <= cmd.first;
      prod_ff <= prod_in;
      fb_ff   <= fa_ff;
      if (vb_ff) acc_ff <= acc_in;
   end

   // rounding of the finished sum
   logic signed [ACC_W-1:0] rnd_rate, rnd16, rnd24;
   logic signed [SIG_W-1:0] res24, res16;
   assign rnd_rate = (acc_ff + RATE_HALF) >>> RATE_SH;
   assign rnd16    = (acc_ff + HALF16) >>> 16;
   assign rnd24    = (acc_ff + HALF24) >>> 24;
   assign res16    = sat32(rnd16);
   assign res24    = sat32(rnd24);

   // write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            mv_ff[i]  <= '0;
            fe_ff[i]  <= '0;
            pbv_ff[i] <= '0;
            ci_ff[i]  <= '0;
            cv_ff[i]  <= '0;
         end
         for (int i = 0; i < 6; i++) sv_ff[i] <= '0;
      end else if (cmd.wb) begin
         case (cmd.phase)
            PH_FILT: begin
               fe_ff[cmd.row[1:0]]  <= res16;
               mv_ff[cmd.row[1:0]]  <= nvm_ff[cmd.row[1:0]];
               old_ff[cmd.row[1:0]] <= sv_ff[cmd.row];
            end
            PH_XS:   sv_ff[cmd.row] <= res24;
            PH_OPT:  sv_ff[cmd.row] <= res24;
            PH_LQR:  ci_ff[cmd.row[1:0]] <= res24;
            PH_VOLT: begin
               cv_ff[cmd.row[1:0]]  <= res24;
               pbv_ff[cmd.row[1:0]] <= vel_ff[cmd.row[1:0]];
            end
            default: ;
         endcase
      end
   end

   // per-tick working values
   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         case (cmd.phase)
            PH_RATE: rate_ff[cmd.row[1:0]] <= RATE_W'(rnd_rate);
            PH_KIN:  vel_ff[cmd.row[1:0]]  <= res24;
            PH_NVM:  nvm_ff[cmd.row[1:0]]  <= res24;
            default: ;
         endcase
      end
   end

   // PWM: 255*|U|/(6<<FRAC_BITS), clipped at 255
   logic [31:0] mag_v [3];
   logic [39:0] x_v   [3];
   logic [39:0] q_v   [3];
   logic [26:0] p_v   [3];
   logic [7:0]  pwm_v [3];
   logic [2:0]  neg_v;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_v[i] = cv_ff[i][SIG_W-1];
         mag_v[i] = neg_v[i] ? (~cv_ff[i] + 32'd1) : cv_ff[i];
         x_v[i]   = ({8'd0, mag_v[i]} << 8) - {8'd0, mag_v[i]};
         q_v[i]   = x_v[i] >> FRAC_BITS;
         p_v[i]   = q_v[i][10:0] * 16'd43691;
         pwm_v[i] = (q_v[i] >= 40'd1536) ? 8'd255 : p_v[i][25:18];
      end
   end

   // result register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_out) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_pwm_1          <= pwm_v[0];
         rsp_pwm_2          <= pwm_v[1];
         rsp_pwm_3          <= pwm_v[2];
         rsp_direction_mask <= neg_v;
         rsp_voltage_1      <= cv_ff[0];
         rsp_voltage_2      <= cv_ff[1];
         rsp_voltage_3      <= cv_ff[2];
         rsp_body_forward   <= vel_ff[0];
         rsp_body_sideways  <= vel_ff[1];
         rsp_body_turn      <= vel_ff[2];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.mode     = mode_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

endmodule

[tb/omni_wheel_velocity_lqr_checker.sv]
`timescale 1ns / 100ps

module omni_wheel_velocity_lqr_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_wheel_speed_1,
   input  logic signed [15:0] req_wheel_speed_2,
   input  logic signed [15:0] req_wheel_speed_3,
   input  logic signed [31:0] req_ref_longitudinal,
   input  logic signed [31:0] req_ref_normal,
   input  logic signed [31:0] req_ref_angular,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [7:0]         rsp_pwm_1,
   input  logic [7:0]         rsp_pwm_2,
   input  logic [7:0]         rsp_pwm_3,
   input  logic [2:0]         rsp_direction_mask,
   input  logic signed [31:0] rsp_voltage_1,
   input  logic signed [31:0] rsp_voltage_2,
   input  logic signed [31:0] rsp_voltage_3,
   input  logic signed [31:0] rsp_body_forward,
   input  logic signed [31:0] rsp_body_sideways,
   input  logic signed [31:0] rsp_body_turn,
   output int                 fail_count,
   output int                 pending
);
   import owv_lqr_pkg::*;

   typedef struct {
      logic [7:0]         pwm [3];
      logic [2:0]         dir_mask;
      logic signed [31:0] volt [3];
      logic signed [31:0] body [3];
   } drive_type;

   // coefficients, 24 fraction bits
   localparam longint RATE_GAIN = 175691;
   localparam longint KIN_M [3][3] = '{'{0, 489895, -489895},
      '{-565392, 281857, 281857}, '{2823605, 2823605, 2823605}};
   localparam longint A_DIAG [3] = '{13787516, 13787516, 9878425};
   localparam longint B_M [3][3] = '{'{0, 671089, -671089},
      '{-773430, 387554, 387554}, '{16555757, 16555757, 16555757}};
   localparam longint K_GAIN [3][6] = '{
      '{0, -123151476, 3325244, 0, -84649443, 5630434},
      '{106652762, 61575738, 3325244, 73308045, 42323883, 5630434},
      '{-106652762, 61575738, 3325244, -73308045, 42323883, 5630434}};

   logic        mode_q;
   logic [15:0] alpha_q;
   longint      model_vel [3];
   longint      filt_err [3];
   longint      xstate [6];
   longint      prev_body [3];
   longint      d_volt [3];
   longint      volt_acc [3];
   drive_type   expected_drive [$];

   function automatic longint round_q(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
   endfunction

   // one control tick: body velocity, predictor, voltage integration and PWM
   function automatic drive_type tick_controller(longint spd [3], longint rf [3]);
      drive_type r;
      longint rate [3], vel [3], nvm [3], old [3], xs [6];
      longint acc, d, u;
      longint a;
      a = longint'(alpha_q);
      for (int i = 0; i < 3; i++) rate[i] = round_q(spd[i] * RATE_GAIN, CF - 16);
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += KIN_M[i][j] * rate[j];
         vel[i] = clamp32(round_q(acc, CF));
      end
      if (!mode_q) begin
         // Smith predictor
         for (int i = 0; i < 3; i++) begin
            acc = A_DIAG[i] * model_vel[i];
            for (int j = 0; j < 3; j++) acc += B_M[i][j] * volt_acc[j];
            nvm[i] = clamp32(round_q(acc, CF));
         end
         for (int i = 0; i < 3; i++) begin
            acc = (vel[i] - model_vel[i]) * (65536 - a) + a * filt_err[i];
            old[i] = xstate[i];
            model_vel[i] = nvm[i];
            filt_err[i] = clamp32(round_q(acc, 16));
            xs[i] = clamp32(nvm[i] + filt_err[i]);
            xstate[i] = xs[i];
         end
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
               acc -= K_GAIN[i][j] * (xs[j] - old[j]);
               acc += K_GAIN[i][j+3] * (rf[j] - xs[j]);
            end
            d_volt[i] = clamp32(round_q(acc, CF));
         end
      end else begin
         // optimal predictor over six states
         for (int i = 0; i < 6; i++) begin
            d = vel[i % 3] - prev_body[i % 3];
            acc = ((i % 3 == 2) ? A_DIAG[2] : A_DIAG[0]) * d;
            if (i >= 3) acc += (longint'(1) <<< CF) * vel[i % 3];
            for (int j = 0; j < 3; j++) acc += B_M[i % 3][j] * d_volt[j];
            xs[i] = clamp32(round_q(acc, CF));
            xstate[i] = xs[i];
         end
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
               acc -= K_GAIN[i][j] * xs[j];
               acc += K_GAIN[i][j+3] * (rf[j] - xs[j+3]);
            end
            d_volt[i] = clamp32(round_q(acc, CF));
         end
      end
      r.dir_mask = '0;
      for (int i = 0; i < 3; i++) begin
         prev_body[i] = vel[i];
         volt_acc[i] = clamp32(volt_acc[i] + d_volt[i]);
         u = volt_acc[i];
         if (u < 0) begin
            r.dir_mask[i] = 1'b1;
            u = -u;
         end
         u = (u * 255) / (longint'(6) <<< 16);
         r.pwm[i] = (u > 255) ? 8'd255 : 8'(u);
         r.volt[i] = 32'(volt_acc[i]);
         r.body[i] = 32'(vel[i]);
      end
      return r;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      drive_type e;
      longint spd [3], rf [3];
      if (reset) begin
         mode_q  = 1'b0;
         alpha_q = ALPHA_RESET;
         for (int i = 0; i < 3; i++) begin
            model_vel[i] = 0; filt_err[i] = 0; prev_body[i] = 0;
            d_volt[i] = 0; volt_acc[i] = 0;
         end
         for (int i = 0; i < 6; i++) xstate[i] = 0;
         expected_drive.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MODE) mode_q = csr_wdata[0];
            else if (csr_index == CSR_ALPHA) alpha_q = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            spd[0] = req_wheel_speed_1; spd[1] = req_wheel_speed_2;
            spd[2] = req_wheel_speed_3;
            rf[0] = req_ref_longitudinal; rf[1] = req_ref_normal;
            rf[2] = req_ref_angular;
            expected_drive.push_back(tick_controller(spd, rf));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_drive.size() == 0) begin
               $error("result transfer with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_drive.pop_front();
               check_field("pwm_1", e.pwm[0], rsp_pwm_1);
               check_field("pwm_2", e.pwm[1], rsp_pwm_2);
               check_field("pwm_3", e.pwm[2], rsp_pwm_3);
               check_field("direction_mask", e.dir_mask, rsp_direction_mask);
               check_field("voltage_1", e.volt[0], rsp_voltage_1);
               check_field("voltage_2", e.volt[1], rsp_voltage_2);
               check_field("voltage_3", e.volt[2], rsp_voltage_3);
               check_field("body_forward", e.body[0], rsp_body_forward);
               check_field("body_sideways", e.body[1], rsp_body_sideways);
               check_field("body_turn", e.body[2], rsp_body_turn);
            end
         end
      end
      pending = expected_drive.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

[tb/tb_omni_wheel_velocity_lqr_controller.sv]
`timescale 1ns / 100ps

module tb_omni_wheel_velocity_lqr_controller;
   import owv_lqr_pkg::*;

   localparam logic [IDX_W-1:0] CSR_SPARE = 8'd2;
   localparam int DRAIN_CYCLES = 200;
   localparam int STALL_LIMIT  = 5000;

   logic               clock, reset;
   logic               csr_valid, csr_ready;
   logic [7:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid, req_stall;
   logic signed [15:0] req_wheel_speed_1, req_wheel_speed_2, req_wheel_speed_3;
   logic signed [31:0] req_ref_longitudinal, req_ref_normal, req_ref_angular;
   logic               rsp_valid, rsp_stall;
   logic [7:0]         rsp_pwm_1, rsp_pwm_2, rsp_pwm_3;
   logic [2:0]         rsp_direction_mask;
   logic signed [31:0] rsp_voltage_1, rsp_voltage_2, rsp_voltage_3;
   logic signed [31:0] rsp_body_forward, rsp_body_sideways, rsp_body_turn;
   int                 fail_count, pending;
   logic               gaps_on;
   int                 quiet_cycles;

   omni_wheel_velocity_lqr_controller DUT (.*);
   omni_wheel_velocity_lqr_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_omni_wheel_velocity_lqr_controller failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side back-pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         n = gaps_on ? $urandom_range(0, 8) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   task automatic send_tick(logic signed [15:0] s1, s2, s3, logic signed [31:0] r1, r2, r3);
      int n;
      n = gaps_on ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_wheel_speed_1 <= s1; req_wheel_speed_2 <= s2; req_wheel_speed_3 <= s3;
      req_ref_longitudinal <= r1; req_ref_normal <= r2; req_ref_angular <= r3;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // only written once the block has drained
   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_speed(bit wide);
      int v;
      v = wide ? $urandom_range(0, 65534) - 32767 : $urandom_range(0, 4000) - 2000;
      return 16'(v);
   endfunction

   function automatic logic signed [31:0] rand_ref(bit wide);
      if (wide) return $urandom;
      return 32'($signed($urandom_range(0, 262144)) - 131072);
   endfunction

   task automatic random_run(int count);
      bit wide;
      for (int k = 0; k < count; k++) begin
         wide = ($urandom_range(0, 9) == 0);
         send_tick(rand_speed(wide), rand_speed(wide), rand_speed(wide),
                   rand_ref(wide), rand_ref(wide), rand_ref(wide));
      end
   endtask

   initial begin
      logic [15:0] alpha_set [4];
      reset = 1'b1;
      gaps_on = 1'b1;
      quiet_cycles = 0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      req_valid = 1'b0;
      req_wheel_speed_1 = '0; req_wheel_speed_2 = '0; req_wheel_speed_3 = '0;
      req_ref_longitudinal = '0; req_ref_normal = '0; req_ref_angular = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes under the Smith predictor at reset alpha
      send_tick(0, 0, 0, 0, 0, 0);
      send_tick(32767, 32767, 32767, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_tick(-32767, -32767, -32767, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_tick(-32768, 32767, -1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0000FFFF);
      send_tick(32767, -32767, 32767, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1);
      send_tick(1, -1, 0, 1, -1, 32'sh00010000);
      send_tick(0, 0, 0, 0, 0, 0);
      // unused register index and unused mode bits are ignored
      write_reg(CSR_SPARE, 16'hFFFF);
      write_reg(CSR_MODE, 16'hFFFE);
      send_tick(300, -200, 100, 32'sh00008000, 0, -32'sh00004000);
      // optimal predictor with saturating drive, then a tiny negative voltage
      write_reg(CSR_MODE, 16'h0001);
      send_tick(32767, 32767, 32767, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_tick(-32767, 32767, -32767, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
      send_tick(0, 0, 0, 0, 0, 0);
      send_tick(0, 0, 0, -32'sd1, 0, 0);
      // alpha extremes, switching mode with shared state
      write_reg(CSR_ALPHA, 16'h0000);
      write_reg(CSR_MODE, 16'h0000);
      send_tick(1000, -1000, 500, 32'sh00020000, -32'sh00010000, 32'sh00008000);
      send_tick(-32767, 0, 32767, 0, 32'sh7FFFFFFF, 0);
      write_reg(CSR_ALPHA, 16'hFFFF);
      send_tick(1000, -1000, 500, 32'sh00020000, -32'sh00010000, 32'sh00008000);
      send_tick(32767, -32767, 0, 32'sh80000000, 0, 32'sh7FFFFFFF);

      // random phases over several settings
      alpha_set[0] = 16'h0000; alpha_set[1] = 16'hFFFF;
      alpha_set[2] = ALPHA_RESET; alpha_set[3] = 16'h5555;
      for (int p = 0; p < 10; p++) begin
         gaps_on = (p % 3 != 2);
         write_reg(CSR_MODE, {15'($urandom), 1'(p % 2)});
         write_reg(CSR_ALPHA, (p < 8) ? alpha_set[(p / 2) % 4] : 16'($urandom));
         random_run(140);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("tb_omni_wheel_velocity_lqr_controller passed");
      else
         $display("tb_omni_wheel_velocity_lqr_controller failed");
      $finish;
   end

endmodule
